@@ hdl/ppc_pkg.sv @@
// Shared constants, codes and types of the parallelepiped pixel classifier.
package ppc_pkg;

	// Defaults of the top-level parameters.
	localparam int DEF_MAX_CLASSES = 16;
	localparam int DEF_MAX_BANDS   = 4;
	localparam int DEF_SAMPLE_BITS = 16;
	localparam int DEF_LABEL_BITS  = 8;

	// Fixed field widths of the item and register interface.
	localparam int SAMPLE_FIELDS  = 4;
	localparam int SLOT_BITS      = 4;
	localparam int BAND_SEL_BITS  = 2;
	localparam int CLASS_CNT_BITS = 5;
	localparam int BAND_CNT_BITS  = 3;
	localparam int NODATA_BITS    = 16;
	localparam int PADDR_BITS     = 5;
	localparam int PDATA_BITS     = 32;

	// Item kinds carried on the mode field.
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_PIXEL = 1'b1;

	// Register indexes, taken from paddr word address.
	typedef enum logic [2:0] {
		REG_CLASSES    = 3'd0,
		REG_BANDS      = 3'd1,
		REG_OVERLAP    = 3'd2,
		REG_NODATA_EN  = 3'd3,
		REG_NODATA_VAL = 3'd4
	} reg_idx_t;

	// Saturating count of the boxes that a pixel has fallen into so far.
	typedef enum logic [1:0] {
		HITS_NONE = 2'd0,
		HITS_ONE  = 2'd1,
		HITS_MANY = 2'd2
	} hits_t;

	// Control part of a token travelling down the chain of cells.
	typedef struct packed {
		logic  valid;
		logic  pixel;
		logic  nodata;
		hits_t hits;
	} tok_ctrl_t;

endpackage

@@ hdl/ppc_cell.sv @@
// One class box of the chain. A load token that names this slot writes the box
// as it enters. A pixel token is compared against the box in the first stage,
// where the squared midpoint distances per band are also formed; the second
// stage sums them and updates the running best match carried by the token.
module ppc_cell #(
	parameter int SAMPLE_BITS  = ppc_pkg::DEF_SAMPLE_BITS,
	parameter int LABEL_BITS   = ppc_pkg::DEF_LABEL_BITS,
	parameter int STORED_BANDS = ppc_pkg::DEF_MAX_BANDS,
	parameter int CELL_IDX     = 0,
	parameter int DIST_BITS    = 2 * (ppc_pkg::DEF_SAMPLE_BITS + 1) + 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic [ppc_pkg::CLASS_CNT_BITS-1:0] classes_in_use,
	input  logic [STORED_BANDS-1:0]            band_en,
	input  ppc_pkg::tok_ctrl_t                 ctrl_i,
	input  logic [ppc_pkg::SLOT_BITS-1:0]      slot_i,
	input  logic [ppc_pkg::BAND_SEL_BITS-1:0]  band_i,
	input  logic [LABEL_BITS-1:0]              label_i,
	input  logic [SAMPLE_BITS-1:0]             lower_i,
	input  logic [SAMPLE_BITS-1:0]             upper_i,
	input  logic [SAMPLE_BITS-1:0]             samp_i [STORED_BANDS],
	input  logic [LABEL_BITS-1:0]              best_label_i,
	input  logic [DIST_BITS-1:0]               best_dist_i,
	output ppc_pkg::tok_ctrl_t                 ctrl_o,
	output logic [ppc_pkg::SLOT_BITS-1:0]      slot_o,
	output logic [ppc_pkg::BAND_SEL_BITS-1:0]  band_o,
	output logic [LABEL_BITS-1:0]              label_o,
	output logic [SAMPLE_BITS-1:0]             lower_o,
	output logic [SAMPLE_BITS-1:0]             upper_o,
	output logic [SAMPLE_BITS-1:0]             samp_o [STORED_BANDS],
	output logic [LABEL_BITS-1:0]              best_label_o,
	output logic [DIST_BITS-1:0]               best_dist_o
);

	localparam int DIFF_BITS = SAMPLE_BITS + 1;
	localparam int SQ_BITS   = 2 * DIFF_BITS;

	// Box held by this cell.
	logic [SAMPLE_BITS-1:0] box_lower_q [STORED_BANDS];
	logic [SAMPLE_BITS-1:0] box_upper_q [STORED_BANDS];
	logic [LABEL_BITS-1:0]  box_label_q;

	logic                   load_hit;
	logic                   active;
	logic [STORED_BANDS-1:0] in_box;
	logic [DIFF_BITS-1:0]   twice_c [STORED_BANDS];
	logic [DIFF_BITS-1:0]   mid2_c  [STORED_BANDS];
	logic [DIFF_BITS-1:0]   diff_c  [STORED_BANDS];
	logic [SQ_BITS-1:0]     sq_c    [STORED_BANDS];
	logic                   hit_c;

	ppc_pkg::tok_ctrl_t            ctrl_s1;
	logic                          hit_s1;
	logic [ppc_pkg::SLOT_BITS-1:0] slot_s1;
	logic [ppc_pkg::BAND_SEL_BITS-1:0] band_s1;
	logic [LABEL_BITS-1:0]         label_s1;
	logic [SAMPLE_BITS-1:0]        lower_s1;
	logic [SAMPLE_BITS-1:0]        upper_s1;
	logic [SAMPLE_BITS-1:0]        samp_s1 [STORED_BANDS];
	logic [LABEL_BITS-1:0]         best_label_s1;
	logic [DIST_BITS-1:0]          best_dist_s1;
	logic [SQ_BITS-1:0]            sq_s1 [STORED_BANDS];
	logic [LABEL_BITS-1:0]         box_label_s1;

	logic [DIST_BITS-1:0]          sum_c;
	ppc_pkg::tok_ctrl_t            ctrl_c;
	logic [LABEL_BITS-1:0]         best_label_c;
	logic [DIST_BITS-1:0]          best_dist_c;

	ppc_pkg::tok_ctrl_t            ctrl_s2;
	logic [ppc_pkg::SLOT_BITS-1:0] slot_s2;
	logic [ppc_pkg::BAND_SEL_BITS-1:0] band_s2;
	logic [LABEL_BITS-1:0]         label_s2;
	logic [SAMPLE_BITS-1:0]        lower_s2;
	logic [SAMPLE_BITS-1:0]        upper_s2;
	logic [SAMPLE_BITS-1:0]        samp_s2 [STORED_BANDS];
	logic [LABEL_BITS-1:0]         best_label_s2;
	logic [DIST_BITS-1:0]          best_dist_s2;

	// A load token for this slot writes the box as it enters the cell.
	assign load_hit = adv && ctrl_i.valid && (ctrl_i.pixel == ppc_pkg::MODE_LOAD) &&
		(int'(slot_i) == CELL_IDX) && (int'(band_i) < STORED_BANDS);

	always_ff @(posedge clk) begin
		if (load_hit) begin
			box_label_q <= label_i;
			for (int b = 0; b < STORED_BANDS; b++) begin
				if (int'(band_i) == b) begin
					box_lower_q[b] <= lower_i;
					box_upper_q[b] <= upper_i;
				end
			end
		end
	end

	// The cell takes part only while its slot is below the class count.
	assign active = int'(classes_in_use) > CELL_IDX;

	// Band test and squared distance to the doubled midpoint.
	always_comb begin
		for (int b = 0; b < STORED_BANDS; b++) begin
			in_box[b]  = !band_en[b] ||
				((samp_i[b] >= box_lower_q[b]) && (samp_i[b] <= box_upper_q[b]));
			twice_c[b] = {samp_i[b], 1'b0};
			mid2_c[b]  = DIFF_BITS'(box_lower_q[b]) + DIFF_BITS'(box_upper_q[b]);
			diff_c[b]  = (twice_c[b] >= mid2_c[b]) ? (twice_c[b] - mid2_c[b]) :
				(mid2_c[b] - twice_c[b]);
			sq_c[b]    = SQ_BITS'(diff_c[b]) * SQ_BITS'(diff_c[b]);
		end
		hit_c = ctrl_i.valid && (ctrl_i.pixel == ppc_pkg::MODE_PIXEL) && active && (&in_box);
	end

	// First stage registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (adv) begin
			ctrl_s1 <= ctrl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s1        <= hit_c;
			slot_s1       <= slot_i;
			band_s1       <= band_i;
			label_s1      <= label_i;
			lower_s1      <= lower_i;
			upper_s1      <= upper_i;
			samp_s1       <= samp_i;
			best_label_s1 <= best_label_i;
			best_dist_s1  <= best_dist_i;
			sq_s1         <= sq_c;
			box_label_s1  <= box_label_q;
		end
	end

	// Sum the band terms and fold this box into the running best match.
	always_comb begin
		sum_c = '0;
		for (int b = 0; b < STORED_BANDS; b++) begin
			if (band_en[b]) begin
				sum_c = sum_c + DIST_BITS'(sq_s1[b]);
			end
		end
		ctrl_c       = ctrl_s1;
		best_label_c = best_label_s1;
		best_dist_c  = best_dist_s1;
		if (hit_s1) begin
			case (ctrl_s1.hits) inside
				ppc_pkg::HITS_ONE, ppc_pkg::HITS_MANY: begin
					ctrl_c.hits = ppc_pkg::HITS_MANY;
					if (sum_c < best_dist_s1) begin
						best_label_c = box_label_s1;
						best_dist_c  = sum_c;
					end
				end
				default: begin
					ctrl_c.hits  = ppc_pkg::HITS_ONE;
					best_label_c = box_label_s1;
					best_dist_c  = sum_c;
				end
			endcase
		end
	end

	// Second stage registers, which are the cell outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else if (adv) begin
			ctrl_s2 <= ctrl_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			slot_s2       <= slot_s1;
			band_s2       <= band_s1;
			label_s2      <= label_s1;
			lower_s2      <= lower_s1;
			upper_s2      <= upper_s1;
			samp_s2       <= samp_s1;
			best_label_s2 <= best_label_c;
			best_dist_s2  <= best_dist_c;
		end
	end

	assign ctrl_o       = ctrl_s2;
	assign slot_o       = slot_s2;
	assign band_o       = band_s2;
	assign label_o      = label_s2;
	assign lower_o      = lower_s2;
	assign upper_o      = upper_s2;
	assign samp_o       = samp_s2;
	assign best_label_o = best_label_s2;
	assign best_dist_o  = best_dist_s2;

endmodule

@@ hdl/parallelepiped_pixel_classifier_unit.sv @@
// Parallelepiped pixel classifier.
// Items enter on item_valid / item_stall. A load item (mode 0) writes the label of
// one class slot and the lower and upper bound of one band of it; it gives no
// result. A pixel item (mode 1) gives one class_label on result_valid /
// result_stall: 0 for nodata, no match or an unresolved overlap, else the label
// of the single matching box or of the nearest matching box midpoint.
// Items walk a chain of MAX_CLASSES cells, one box per cell; a pixel's result leaves
// through an output register after the last cell. One item is accepted per cycle
// while item_stall is low; loads travel the same chain, so they take effect in order
// with the pixels around them.
// While a result waits under result_stall the whole chain holds and item_stall
// is high; nothing is lost or repeated.
// Reset clears the chain and output valid flags and sets the registers to their
// defaults (1 class, 4 bands, overlap gives 0, nodata off). The box table is not
// cleared and must be loaded before use.
// Registers sit on an APB-style port at byte address 4*index; pready is always high.
// The user sees they are written only while no item is in flight; nothing enforces it.
module parallelepiped_pixel_classifier_unit #(
	parameter int MAX_CLASSES = ppc_pkg::DEF_MAX_CLASSES,
	parameter int MAX_BANDS   = ppc_pkg::DEF_MAX_BANDS,
	parameter int SAMPLE_BITS = ppc_pkg::DEF_SAMPLE_BITS,
	parameter int LABEL_BITS  = ppc_pkg::DEF_LABEL_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic                              mode,
	input  logic [ppc_pkg::SLOT_BITS-1:0]     slot,
	input  logic [ppc_pkg::BAND_SEL_BITS-1:0] band_select,
	input  logic [LABEL_BITS-1:0]             label,
	input  logic [SAMPLE_BITS-1:0]            lower_bound,
	input  logic [SAMPLE_BITS-1:0]            upper_bound,
	input  logic [SAMPLE_BITS-1:0]            sample_band0,
	input  logic [SAMPLE_BITS-1:0]            sample_band1,
	input  logic [SAMPLE_BITS-1:0]            sample_band2,
	input  logic [SAMPLE_BITS-1:0]            sample_band3,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [LABEL_BITS-1:0]             class_label,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ppc_pkg::PADDR_BITS-1:0]    paddr,
	input  logic [ppc_pkg::PDATA_BITS-1:0]    pwdata,
	output logic [ppc_pkg::PDATA_BITS-1:0]    prdata,
	output logic                              pready
);

	localparam int STORED_BANDS = (MAX_BANDS < ppc_pkg::SAMPLE_FIELDS) ? MAX_BANDS :
		ppc_pkg::SAMPLE_FIELDS;
	localparam int DIST_BITS = 2 * (SAMPLE_BITS + 1) + 2;

	logic [ppc_pkg::CLASS_CNT_BITS-1:0] classes_q;
	logic [ppc_pkg::BAND_CNT_BITS-1:0]  bands_q;
	logic                               overlap_q;
	logic                               nodata_en_q;
	logic [ppc_pkg::NODATA_BITS-1:0]    nodata_val_q;

	logic                      cfg_write;
	ppc_pkg::reg_idx_t         cfg_idx;
	logic [STORED_BANDS-1:0]   band_en;
	logic                      adv;
	logic [SAMPLE_BITS-1:0]    samp_all [ppc_pkg::SAMPLE_FIELDS];

	ppc_pkg::tok_ctrl_t                ch_ctrl       [MAX_CLASSES+1];
	logic [ppc_pkg::SLOT_BITS-1:0]     ch_slot       [MAX_CLASSES+1];
	logic [ppc_pkg::BAND_SEL_BITS-1:0] ch_band       [MAX_CLASSES+1];
	logic [LABEL_BITS-1:0]             ch_label      [MAX_CLASSES+1];
	logic [SAMPLE_BITS-1:0]            ch_lower      [MAX_CLASSES+1];
	logic [SAMPLE_BITS-1:0]            ch_upper      [MAX_CLASSES+1];
	logic [SAMPLE_BITS-1:0]            ch_samp       [MAX_CLASSES+1][STORED_BANDS];
	logic [LABEL_BITS-1:0]             ch_best_label [MAX_CLASSES+1];
	logic [DIST_BITS-1:0]              ch_best_dist  [MAX_CLASSES+1];

	logic                    result_valid_q;
	logic [LABEL_BITS-1:0]   class_label_q;
	logic [LABEL_BITS-1:0]   result_c;
	ppc_pkg::tok_ctrl_t      last_ctrl;

	// Register port.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_idx   = ppc_pkg::reg_idx_t'(paddr[ppc_pkg::PADDR_BITS-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			classes_q    <= ppc_pkg::CLASS_CNT_BITS'(1);
			bands_q      <= ppc_pkg::BAND_CNT_BITS'(4);
			overlap_q    <= 1'b0;
			nodata_en_q  <= 1'b0;
			nodata_val_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_idx)
				ppc_pkg::REG_CLASSES:    classes_q    <= pwdata[ppc_pkg::CLASS_CNT_BITS-1:0];
				ppc_pkg::REG_BANDS:      bands_q      <= pwdata[ppc_pkg::BAND_CNT_BITS-1:0];
				ppc_pkg::REG_OVERLAP:    overlap_q    <= pwdata[0];
				ppc_pkg::REG_NODATA_EN:  nodata_en_q  <= pwdata[0];
				ppc_pkg::REG_NODATA_VAL: nodata_val_q <= pwdata[ppc_pkg::NODATA_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			ppc_pkg::REG_CLASSES:    prdata = ppc_pkg::PDATA_BITS'(classes_q);
			ppc_pkg::REG_BANDS:      prdata = ppc_pkg::PDATA_BITS'(bands_q);
			ppc_pkg::REG_OVERLAP:    prdata = ppc_pkg::PDATA_BITS'(overlap_q);
			ppc_pkg::REG_NODATA_EN:  prdata = ppc_pkg::PDATA_BITS'(nodata_en_q);
			ppc_pkg::REG_NODATA_VAL: prdata = ppc_pkg::PDATA_BITS'(nodata_val_q);
			default:                 prdata = '0;
		endcase
	end

	// Band 0 is always compared; a count of zero acts as one.
	always_comb begin
		for (int b = 0; b < STORED_BANDS; b++) begin
			band_en[b] = (b == 0) || (b < int'(bands_q));
		end
	end

	// The chain moves whenever the output register is free or being emptied.
	assign adv        = !result_valid_q || !result_stall;
	assign item_stall = !adv;

	// Token entering the first cell.
	assign samp_all[0] = sample_band0;
	assign samp_all[1] = sample_band1;
	assign samp_all[2] = sample_band2;
	assign samp_all[3] = sample_band3;

	always_comb begin
		ch_ctrl[0].valid  = item_valid;
		ch_ctrl[0].pixel  = mode;
		ch_ctrl[0].nodata = nodata_en_q && (sample_band0 == SAMPLE_BITS'(nodata_val_q));
		ch_ctrl[0].hits   = ppc_pkg::HITS_NONE;
		for (int b = 0; b < STORED_BANDS; b++) begin
			ch_samp[0][b] = samp_all[b];
		end
	end

	assign ch_slot[0]       = slot;
	assign ch_band[0]       = band_select;
	assign ch_label[0]      = label;
	assign ch_lower[0]      = lower_bound;
	assign ch_upper[0]      = upper_bound;
	assign ch_best_label[0] = '0;
	assign ch_best_dist[0]  = '0;

	// One cell per class slot.
	for (genvar c = 0; c < MAX_CLASSES; c++) begin : g_cell
		ppc_cell #(
			.SAMPLE_BITS  (SAMPLE_BITS),
			.LABEL_BITS   (LABEL_BITS),
			.STORED_BANDS (STORED_BANDS),
			.CELL_IDX     (c),
			.DIST_BITS    (DIST_BITS)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.adv            (adv),
			.classes_in_use (classes_q),
			.band_en        (band_en),
			.ctrl_i         (ch_ctrl[c]),
			.slot_i         (ch_slot[c]),
			.band_i         (ch_band[c]),
			.label_i        (ch_label[c]),
			.lower_i        (ch_lower[c]),
			.upper_i        (ch_upper[c]),
			.samp_i         (ch_samp[c]),
			.best_label_i   (ch_best_label[c]),
			.best_dist_i    (ch_best_dist[c]),
			.ctrl_o         (ch_ctrl[c+1]),
			.slot_o         (ch_slot[c+1]),
			.band_o         (ch_band[c+1]),
			.label_o        (ch_label[c+1]),
			.lower_o        (ch_lower[c+1]),
			.upper_o        (ch_upper[c+1]),
			.samp_o         (ch_samp[c+1]),
			.best_label_o   (ch_best_label[c+1]),
			.best_dist_o    (ch_best_dist[c+1])
		);
	end

	// Final decision from the match count and the overlap policy.
	assign last_ctrl = ch_ctrl[MAX_CLASSES];

	always_comb begin
		result_c = '0;
		if (!last_ctrl.nodata) begin
			case (last_ctrl.hits)
				ppc_pkg::HITS_ONE:  result_c = ch_best_label[MAX_CLASSES];
				ppc_pkg::HITS_MANY: result_c = overlap_q ? ch_best_label[MAX_CLASSES] : '0;
				default:            result_c = '0;
			endcase
		end
	end

	// Output register; load tokens leave the chain here without a result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= last_ctrl.valid && (last_ctrl.pixel == ppc_pkg::MODE_PIXEL);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			class_label_q <= result_c;
		end
	end

	assign result_valid = result_valid_q;
	assign class_label  = class_label_q;

endmodule

@@ hdl/ppc_checker.sv @@
// Port-level checks of the classifier, attached to every instance of the top level.
module ppc_checker #(
	parameter int LABEL_BITS = ppc_pkg::DEF_LABEL_BITS
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  item_stall,
	input logic                  result_valid,
	input logic                  result_stall,
	input logic [LABEL_BITS-1:0] class_label,
	input logic                  pready
);

	// A stalled result stays offered.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its label.
	a_label_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(class_label))
		else $error("result label changed while stalled");

	// The input side halts exactly while a finished result is held back.
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall == (result_valid && result_stall))
		else $error("item stall does not follow the output register");

	// The register port never inserts wait states.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("register port not ready");

endmodule

bind parallelepiped_pixel_classifier_unit ppc_checker #(
	.LABEL_BITS (LABEL_BITS)
) u_ppc_checker (.*);

@@ tb/parallelepiped_pixel_classifier_unit_tb.sv @@
`timescale 1ns / 100ps

module parallelepiped_pixel_classifier_unit_tb;

	localparam int CLASSES       = ppc_pkg::DEF_MAX_CLASSES;
	localparam int BANDS         = ppc_pkg::DEF_MAX_BANDS;
	localparam int SW            = ppc_pkg::DEF_SAMPLE_BITS;
	localparam int LW            = ppc_pkg::DEF_LABEL_BITS;
	localparam int NSF           = ppc_pkg::SAMPLE_FIELDS;
	localparam int MAX_SAMPLE    = (1 << SW) - 1;
	localparam int MAX_LABEL     = (1 << LW) - 1;
	localparam int CHAIN_CYCLES  = 2 * CLASSES + 1;
	localparam int SETTLE_CYCLES = CHAIN_CYCLES + 8;
	localparam int PHASES        = 11;
	localparam int PHASE_ITEMS   = 115;
	localparam int LONG_HOLD     = 160;

	// One input transaction as it appears on the item ports.
	typedef struct packed {
		logic                                  mode;
		logic [ppc_pkg::SLOT_BITS-1:0]         slot;
		logic [ppc_pkg::BAND_SEL_BITS-1:0]     band;
		logic [LW-1:0]                         label;
		logic [SW-1:0]                         lower;
		logic [SW-1:0]                         upper;
		logic [NSF-1:0][SW-1:0]                sample;
	} item_t;

	typedef struct packed {
		logic [LW-1:0] label;
		logic [4:0]    hits;
	} verdict_t;

	logic                             clk          = 1'b0;
	logic                             arst_n       = 1'b0;
	logic                             item_valid   = 1'b0;
	logic                             item_stall;
	logic                             result_valid;
	logic                             result_stall = 1'b0;
	logic [LW-1:0]                    class_label;
	logic                             psel         = 1'b0;
	logic                             penable      = 1'b0;
	logic                             pwrite       = 1'b0;
	logic [ppc_pkg::PADDR_BITS-1:0]   paddr        = '0;
	logic [ppc_pkg::PDATA_BITS-1:0]   pwdata       = '0;
	logic [ppc_pkg::PDATA_BITS-1:0]   prdata;
	logic                             pready;

	item_t                   drv_item     = '0;
	item_t                   item_backlog[$];
	logic [LW-1:0]           expected_labels[$];

	// Box table as the classifier should hold it, updated as loads are accepted.
	logic [SW-1:0]           tbl_lo [CLASSES][BANDS];
	logic [SW-1:0]           tbl_hi [CLASSES][BANDS];
	logic [LW-1:0]           tbl_label [CLASSES];

	// Box table as planned by the stimulus, in queue order.
	logic [SW-1:0]           plan_lo [CLASSES][BANDS];
	logic [SW-1:0]           plan_hi [CLASSES][BANDS];
	bit                      plan_written [CLASSES][BANDS];

	// Register copies, starting from their reset values.
	logic [ppc_pkg::CLASS_CNT_BITS-1:0] cfg_classes    = 5'd1;
	logic [ppc_pkg::BAND_CNT_BITS-1:0]  cfg_bands      = 3'd4;
	logic                               cfg_overlap    = 1'b0;
	logic                               cfg_nodata_en  = 1'b0;
	logic [ppc_pkg::NODATA_BITS-1:0]    cfg_nodata_val = '0;

	logic        item_fire  = 1'b0;
	logic        label_fire = 1'b0;
	int unsigned tx_wait = 0;
	int unsigned rx_wait = 0;
	int unsigned accepted_items = 0;
	int unsigned load_count = 0;
	int unsigned pixel_count = 0;
	int unsigned overlap_pixels = 0;
	int unsigned results_seen = 0;
	int unsigned settings_used = 0;
	int unsigned mismatches = 0;

	int ph_classes [PHASES];
	int ph_bands   [PHASES];
	int ph_overlap [PHASES];
	int ph_nd_en   [PHASES];
	int ph_nd_val  [PHASES];

	parallelepiped_pixel_classifier_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.mode         (drv_item.mode),
		.slot         (drv_item.slot),
		.band_select  (drv_item.band),
		.label        (drv_item.label),
		.lower_bound  (drv_item.lower),
		.upper_bound  (drv_item.upper),
		.sample_band0 (drv_item.sample[0]),
		.sample_band1 (drv_item.sample[1]),
		.sample_band2 (drv_item.sample[2]),
		.sample_band3 (drv_item.sample[3]),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.class_label  (class_label),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #10 clk = ~clk;

	// Class count as the hardware applies it: values above the table size saturate.
	function automatic int active_classes();
		return (cfg_classes > CLASSES) ? CLASSES : int'(cfg_classes);
	endfunction

	// Band count: zero means one band, large values saturate.
	function automatic int active_bands();
		int nb;
		nb = (cfg_bands == 0) ? 1 : int'(cfg_bands);
		if (nb > BANDS) nb = BANDS;
		if (nb > NSF) nb = NSF;
		return nb;
	endfunction

	// Works out the label of a pixel from the current box table and registers.
	// Midpoints stay doubled, so every distance term is an exact integer.
	function automatic verdict_t classify_pixel(input logic [NSF-1:0][SW-1:0] smp);
		verdict_t    v;
		logic [63:0] twice, mid2, diff, sq_sum, best_sum;
		logic [LW-1:0] first_lbl, best_lbl;
		bit          hit;
		int          hits;
		v = '0;
		if (cfg_nodata_en && smp[0] == cfg_nodata_val) return v;
		hits = 0;
		best_sum = '0;
		first_lbl = '0;
		best_lbl = '0;
		for (int c = 0; c < active_classes(); c++) begin
			hit = 1'b1;
			sq_sum = '0;
			for (int b = 0; b < active_bands(); b++) begin
				if (smp[b] < tbl_lo[c][b] || smp[b] > tbl_hi[c][b]) begin
					hit = 1'b0;
				end else begin
					twice = {47'd0, smp[b], 1'b0};
					mid2 = 64'(tbl_lo[c][b]);
					mid2 = mid2 + 64'(tbl_hi[c][b]);
					diff = (twice >= mid2) ? twice - mid2 : mid2 - twice;
					sq_sum = sq_sum + diff * diff;
				end
			end
			if (hit) begin
				if (hits == 0) begin
					first_lbl = tbl_label[c];
					best_lbl = tbl_label[c];
					best_sum = sq_sum;
				end else if (sq_sum < best_sum) begin
					best_sum = sq_sum;
					best_lbl = tbl_label[c];
				end
				hits++;
			end
		end
		v.hits = 5'(hits);
		if (hits == 1) v.label = first_lbl;
		else if (hits > 1 && cfg_overlap) v.label = best_lbl;
		return v;
	endfunction

	task automatic flag_mismatch(input string what, input logic [LW-1:0] want,
			input logic [LW-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] %s: expected class_label %0d, got %0d", $time, what, want, got);
	endtask

	// Queues a load transaction; the unused pixel fields carry random values.
	task automatic push_load(input int s, input int b, input int lbl,
			input logic [SW-1:0] lo, input logic [SW-1:0] hi);
		item_t it;
		it.mode = ppc_pkg::MODE_LOAD;
		it.slot = ppc_pkg::SLOT_BITS'(s);
		it.band = ppc_pkg::BAND_SEL_BITS'(b);
		it.label = LW'(lbl);
		it.lower = lo;
		it.upper = hi;
		for (int k = 0; k < NSF; k++) it.sample[k] = SW'($urandom_range(0, MAX_SAMPLE));
		plan_lo[s][b] = lo;
		plan_hi[s][b] = hi;
		plan_written[s][b] = 1'b1;
		item_backlog = {item_backlog, it};
	endtask

	// Queues a pixel transaction; the unused load fields carry random values.
	task automatic push_pixel(input logic [NSF-1:0][SW-1:0] smp);
		item_t it;
		it.mode = ppc_pkg::MODE_PIXEL;
		it.slot = ppc_pkg::SLOT_BITS'($urandom_range(0, CLASSES - 1));
		it.band = ppc_pkg::BAND_SEL_BITS'($urandom_range(0, BANDS - 1));
		it.label = LW'($urandom_range(0, MAX_LABEL));
		it.lower = SW'($urandom_range(0, MAX_SAMPLE));
		it.upper = SW'($urandom_range(0, MAX_SAMPLE));
		it.sample = smp;
		item_backlog = {item_backlog, it};
	endtask

	// Draws one band of a box. Many boxes cluster so that overlaps are common;
	// some are full range, single points or inverted.
	task automatic draw_box(output logic [SW-1:0] lo, output logic [SW-1:0] hi);
		int r, a, z;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			a = 0;
			z = MAX_SAMPLE;
		end else if (r < 10) begin
			a = $urandom_range(1, MAX_SAMPLE);
			z = $urandom_range(0, a - 1);
		end else if (r < 15) begin
			a = $urandom_range(0, 1) ? MAX_SAMPLE : $urandom_range(0, MAX_SAMPLE);
			z = a;
		end else if (r < 60) begin
			a = 30000 + $urandom_range(0, 4000);
			r = $urandom_range(0, 3000);
			z = a + r;
			a = a - r;
		end else begin
			a = $urandom_range(0, MAX_SAMPLE);
			z = a + $urandom_range(0, MAX_SAMPLE - a);
		end
		lo = SW'(a);
		hi = SW'(z);
	endtask

	// Waits until every queued transaction is taken and every result has come.
	task automatic wait_for_quiet();
		do @(posedge clk);
		while (item_backlog.size() != 0 || item_valid || expected_labels.size() != 0);
	endtask

	// Writes one register, then reads it back on the port.
	task automatic write_reg(input ppc_pkg::reg_idx_t idx,
			input logic [ppc_pkg::PDATA_BITS-1:0] value);
		logic [ppc_pkg::PDATA_BITS-1:0] readback;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			ppc_pkg::REG_CLASSES: begin
				cfg_classes = value[ppc_pkg::CLASS_CNT_BITS-1:0];
				readback = ppc_pkg::PDATA_BITS'(cfg_classes);
			end
			ppc_pkg::REG_BANDS: begin
				cfg_bands = value[ppc_pkg::BAND_CNT_BITS-1:0];
				readback = ppc_pkg::PDATA_BITS'(cfg_bands);
			end
			ppc_pkg::REG_OVERLAP: begin
				cfg_overlap = value[0];
				readback = ppc_pkg::PDATA_BITS'(cfg_overlap);
			end
			ppc_pkg::REG_NODATA_EN: begin
				cfg_nodata_en = value[0];
				readback = ppc_pkg::PDATA_BITS'(cfg_nodata_en);
			end
			ppc_pkg::REG_NODATA_VAL: begin
				cfg_nodata_val = value[ppc_pkg::NODATA_BITS-1:0];
				readback = ppc_pkg::PDATA_BITS'(cfg_nodata_val);
			end
			default: readback = '0;
		endcase
		if (prdata !== readback) begin
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] register %0d reads %0h, expected %0h", $time, idx, prdata,
					readback);
		end
	endtask

	// Loads move down the chain and give no result, so the pipe is given time
	// to empty before any register changes.
	task automatic apply_setting(input int classes, input int bands, input int overlap,
			input int nd_en, input int nd_val);
		wait_for_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(ppc_pkg::REG_CLASSES, classes);
		write_reg(ppc_pkg::REG_BANDS, bands);
		write_reg(ppc_pkg::REG_OVERLAP, overlap);
		write_reg(ppc_pkg::REG_NODATA_EN, nd_en);
		write_reg(ppc_pkg::REG_NODATA_VAL, nd_val);
		settings_used++;
	endtask

	// Sender: presents queued transactions and idles for a drawn number of
	// cycles after each one, with stretches of back-to-back traffic.
	always @(negedge clk) begin
		int unsigned w;
		if (arst_n && (!item_valid || item_fire)) begin
			if (item_fire)
				w = ((accepted_items / 96) % 3 == 0) ? 0 : $urandom_range(0, 17);
			else
				w = tx_wait;
			if (w > 0) begin
				item_valid <= 1'b0;
				tx_wait <= w - 1;
			end else if (item_backlog.size() != 0) begin
				drv_item <= item_backlog.pop_front();
				item_valid <= 1'b1;
				tx_wait <= 0;
			end else begin
				item_valid <= 1'b0;
				tx_wait <= 0;
			end
		end
	end

	// Receiver: stalls for a drawn number of cycles after each result, and twice
	// holds off for a long stretch so that the chain fills and stalls its input.
	always @(negedge clk) begin
		int unsigned w;
		if (arst_n) begin
			if (label_fire && (results_seen == 250 || results_seen == 750))
				w = LONG_HOLD;
			else if (label_fire)
				w = ((results_seen / 80) % 3 == 0) ? 0 : $urandom_range(0, 17);
			else
				w = rx_wait;
			if (w > 0) begin
				result_stall <= 1'b1;
				rx_wait <= w - 1;
			end else begin
				result_stall <= 1'b0;
				rx_wait <= 0;
			end
		end
	end

	// Accepted items update the expected table or queue a predicted label;
	// accepted results are checked against the oldest prediction.
	always @(posedge clk) begin
		verdict_t v;
		logic [LW-1:0] want;
		if (arst_n) begin
			item_fire <= item_valid && !item_stall;
			label_fire <= result_valid && !result_stall;
			if (item_valid && !item_stall) begin
				accepted_items++;
				if (drv_item.mode == ppc_pkg::MODE_LOAD) begin
					tbl_label[drv_item.slot] = drv_item.label;
					tbl_lo[drv_item.slot][drv_item.band] = drv_item.lower;
					tbl_hi[drv_item.slot][drv_item.band] = drv_item.upper;
					load_count++;
				end else begin
					v = classify_pixel(drv_item.sample);
					expected_labels = {expected_labels, v.label};
					pixel_count++;
					if (v.hits > 1) overlap_pixels++;
				end
			end
			if (result_valid && !result_stall) begin
				results_seen++;
				if (expected_labels.size() == 0) begin
					flag_mismatch("result with no pixel pending", '0, class_label);
				end else begin
					want = expected_labels.pop_front();
					if (class_label !== want)
						flag_mismatch("wrong class_label", want, class_label);
				end
			end
		end
	end

	// Stimulus: a directed opening, then random phases over several settings.
	initial begin
		logic [SW-1:0] lo, hi;
		logic [NSF-1:0][SW-1:0] smp;
		int r, c, a, z;

		ph_classes = '{16, 31, 0, 1, 5, 16, -1, 2, 16, 31, -1};
		ph_bands   = '{4, 7, 1, 0, 3, 2, -1, 4, 1, 4, -1};
		ph_overlap = '{1, 0, 1, 0, 1, 1, -1, 1, 0, 1, -1};
		ph_nd_en   = '{0, 1, 0, 1, 0, 1, -1, 0, 1, 1, -1};
		ph_nd_val  = '{-1, 65535, 0, 0, -1, -1, -1, -1, 0, -1, -1};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: one class over four bands, full-range box.
		for (int b = 0; b < BANDS; b++) push_load(0, b, 8'h5A, '0, SW'(MAX_SAMPLE));
		push_pixel('0);
		push_pixel({NSF{16'hFFFF}});

		// Four classes over two bands with nodata on: overlap, no match,
		// single match, inverted box and a nodata pixel.
		apply_setting(4, 2, 0, 1, 1234);
		push_load(0, 0, 1, 150, 400);
		push_load(0, 1, 1, 150, 400);
		push_load(1, 0, 8'hAA, 100, 200);
		push_load(1, 1, 8'hAA, 100, 200);
		push_load(2, 0, MAX_LABEL, 300, 200);
		push_load(2, 1, MAX_LABEL, 0, SW'(MAX_SAMPLE));
		push_load(3, 0, 0, 100, 200);
		push_load(3, 1, 0, 100, 200);
		push_pixel({16'd0, 16'd0, 16'd160, 16'd1234});
		push_pixel({16'd7, 16'd9, 16'd160, 16'd160});
		push_pixel({16'd0, 16'd0, 16'd50, 16'd50});
		push_pixel({16'd0, 16'd0, 16'd300, 16'd300});
		push_pixel({16'd0, 16'd0, 16'd0, 16'hFFFF});

		// Nearest midpoint: two equal boxes tie and the lower slot wins.
		apply_setting(4, 2, 1, 1, 1234);
		push_pixel({16'd0, 16'd0, 16'd160, 16'd160});
		push_pixel({16'd0, 16'd0, 16'd380, 16'd380});

		for (int p = 0; p < PHASES; p++) begin
			apply_setting(
				(ph_classes[p] < 0) ? $urandom_range(0, 31) : ph_classes[p],
				(ph_bands[p] < 0) ? $urandom_range(0, 7) : ph_bands[p],
				(ph_overlap[p] < 0) ? $urandom_range(0, 1) : ph_overlap[p],
				(ph_nd_en[p] < 0) ? $urandom_range(0, 1) : ph_nd_en[p],
				(ph_nd_val[p] < 0) ? $urandom_range(0, MAX_SAMPLE) : ph_nd_val[p]);

			// Every box band that this setting reads is loaded before any pixel.
			for (int s = 0; s < active_classes(); s++)
				for (int b = 0; b < active_bands(); b++)
					if (!plan_written[s][b]) begin
						draw_box(lo, hi);
						push_load(s, b, $urandom_range(0, MAX_LABEL), lo, hi);
					end

			for (int k = 0; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				if (r < 22) begin
					draw_box(lo, hi);
					push_load($urandom_range(0, CLASSES - 1), $urandom_range(0, BANDS - 1),
						$urandom_range(0, MAX_LABEL), lo, hi);
				end else begin
					for (int b = 0; b < NSF; b++)
						smp[b] = SW'($urandom_range(0, MAX_SAMPLE));
					if (r < 28) begin
						// Noise pixels, leaning on the ends of the range.
						for (int b = 0; b < NSF; b++)
							case ($urandom_range(0, 2))
								0: smp[b] = '0;
								1: smp[b] = SW'(MAX_SAMPLE);
								default: ;
							endcase
					end else if (active_classes() > 0) begin
						// Aim inside one box, sometimes right on its edges.
						c = $urandom_range(0, active_classes() - 1);
						for (int b = 0; b < active_bands(); b++)
							if (plan_lo[c][b] <= plan_hi[c][b]) begin
								a = int'(plan_lo[c][b]);
								z = int'(plan_hi[c][b]);
								case ($urandom_range(0, 9))
									0: smp[b] = SW'(a);
									1: smp[b] = SW'(z);
									default: smp[b] = SW'(a + $urandom_range(0, z - a));
								endcase
							end
					end
					if (r > 93) smp[0] = cfg_nodata_val;
					push_pixel(smp);
				end
			end
		end

		wait_for_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_labels.size() != 0) begin
			mismatches += expected_labels.size();
			$display("%0d expected results never arrived", expected_labels.size());
		end

		$display("Covered %0d load and %0d pixel transactions over %0d register settings.",
			load_count, pixel_count, settings_used);
		$display("Checked %0d results, %0d pixels inside several boxes, %0d mismatches.",
			results_seen, overlap_pixels, mismatches);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("Timed out with %0d results outstanding", expected_labels.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule
